// ----- rtl/core/encoder_velocity_estimator_core_macros.svh -----
// Assertion macros shared by the encoder velocity estimator RTL
`ifndef ENCODER_VELOCITY_ESTIMATOR_CORE_MACROS_SVH
`define ENCODER_VELOCITY_ESTIMATOR_CORE_MACROS_SVH

// Same-cycle implication
`define EVEL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define EVEL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/evel_pkg.sv -----
// Shared types, constants and helpers of the encoder velocity estimator
package evel_pkg;

  localparam int COUNT_W    = 16;
  localparam int DT_W       = 20;
  localparam int VEL_W      = 32;
  localparam int POS_W      = 48;
  localparam int ALPHA_W    = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int DIV_NW     = 52;
  localparam int DIV_DW     = 33;
  localparam int DIV_CNT_W  = $clog2(DIV_NW + 1);

  localparam logic [27:0]        RAW_SCALE = 28'd256000000;
  localparam logic [DIV_DW-1:0]  US_PER_S  = 33'd1000000;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;
  localparam logic [15:0]        GEAR_MIN  = 16'd3;
  localparam logic [15:0]        GEAR_UNIT = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD     = 3'd0,
    CFG_ALPHA      = 3'd1,
    CFG_CPR        = 3'd2,
    CFG_SINGLE     = 3'd3,
    CFG_AFTER_GEAR = 3'd4,
    CFG_GEAR       = 3'd5,
    CFG_INVERT     = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Signed 32-bit result from a sign and an unsigned quotient, saturating
  function automatic logic signed [VEL_W-1:0] sat_mag(input logic neg,
                                                      input logic [DIV_NW-1:0] q);
    logic signed [VEL_W-1:0] r;
    if (neg) begin
      if (q >= {{(DIV_NW-VEL_W){1'b0}}, 1'b1, {(VEL_W-1){1'b0}}})
        r = {1'b1, {(VEL_W-1){1'b0}}};
      else
        r = -$signed(q[VEL_W-1:0]);
    end else begin
      if (q >= {{(DIV_NW-VEL_W){1'b0}}, 1'b0, {(VEL_W-1){1'b1}}})
        r = {1'b0, {(VEL_W-1){1'b1}}};
      else
        r = $signed(q[VEL_W-1:0]);
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/evel_if.sv -----
// Stream interfaces: input sample word and result word
interface evel_in_if;
  import evel_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] count;
  logic               counting_down;
  logic [DT_W-1:0]    dt_us;
  modport source (output valid, count, counting_down, dt_us, input ready);
  modport sink (input valid, count, counting_down, dt_us, output ready);
endinterface

interface evel_out_if;
  import evel_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] velocity;
  logic signed [POS_W-1:0] position;
  logic                    valid_res;
  modport source (output valid, velocity, position, valid_res, input ready);
  modport sink (input valid, velocity, position, valid_res, output ready);
endinterface

// ----- rtl/core/evel_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle
module evel_div import evel_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  div_req_t          req,
  output div_stat_t         stat,
  output logic [DIV_NW-1:0] quo
);

  logic [DIV_NW-1:0]    work;
  logic [DIV_DW:0]      rem;
  logic [DIV_DW-1:0]    den;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [DIV_DW:0]      trial;
  logic                 ge;

  // shift next numerator bit into the remainder and try a subtract
  assign trial = {rem[DIV_DW-1:0], work[DIV_NW-1]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_NW);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      work <= req.num;
      den  <= req.den;
      rem  <= '0;
    end else if (busy) begin
      rem  <= ge ? trial - {1'b0, den} : trial;
      work <= {work[DIV_NW-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quo       = work;

endmodule

// ----- rtl/core/encoder_velocity_estimator_core.sv -----
// Encoder velocity estimator top level
// An accepted word is processed alone. The unwrap happens at accept; the raw
// speed, the scaling to rev/s and the position step are three divisions that
// share one bit-serial divider, with the IIR filter and the reduction factor
// worked out between them. A word with dt_us of zero skips the divisions and
// goes from accept straight to the final state. A finished result sits in an
// output register, so the next word may be accepted while it waits to be
// taken; a second result waits in the final state until the first one is
// taken.
module encoder_velocity_estimator_core import evel_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  evel_in_if.sink               sample,
  evel_out_if.source            result
);

`include "encoder_velocity_estimator_core_macros.svh"

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_MUL1   = 10'b0000000010,
    ST_DIV1   = 10'b0000000100,
    ST_FILT1  = 10'b0000001000,
    ST_FILT2  = 10'b0000010000,
    ST_VSTART = 10'b0000100000,
    ST_DIV2   = 10'b0001000000,
    ST_MUL3   = 10'b0010000000,
    ST_DIV3   = 10'b0100000000,
    ST_DONE   = 10'b1000000000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [COUNT_W-1:0] counter_period;
  logic [ALPHA_W-1:0] filter_alpha;
  logic [15:0]        counts_per_rev;
  logic               single_channel;
  logic               after_gear;
  logic [15:0]        gear_ratio;
  logic               inverted;

  // item state
  logic [COUNT_W-1:0]      last_count;
  logic signed [VEL_W-1:0] filt;
  logic signed [POS_W-1:0] pos_accum;

  // per-word working registers
  logic signed [17:0]      delta;
  logic [DT_W-1:0]         dt;
  logic                    zero_dt;
  logic signed [VEL_W-1:0] raw;
  logic signed [50:0]      prod;
  logic [DIV_DW-1:0]       den;
  logic signed [VEL_W-1:0] vel;

  // output register
  logic                    out_valid;
  logic signed [VEL_W-1:0] out_vel;
  logic signed [POS_W-1:0] out_pos;
  logic                    out_vres;

  div_req_t          div_req;
  div_stat_t         div_stat;
  logic [DIV_NW-1:0] div_quo;

  evel_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .stat (div_stat),
    .quo  (div_quo)
  );

  logic               accept;
  logic signed [17:0] d0;
  logic signed [17:0] d_unwrap;
  logic [16:0]        delta_mag;
  logic [VEL_W-1:0]   filt_mag;
  logic [VEL_W-1:0]   vel_mag;
  logic signed [32:0] diff;
  logic signed [35:0] filt_sum;
  logic [15:0]        cpr_eff;
  logic [16:0]        chan_eff;
  logic [15:0]        gear_eff;
  logic               out_take;

  assign accept    = sample.valid && sample.ready;
  assign sample.ready = (state == ST_IDLE);
  assign out_take  = out_valid && result.ready;

  // count difference unwrapped in the counting direction
  always_comb begin
    d0 = $signed({2'b00, sample.count}) - $signed({2'b00, last_count});
    d_unwrap = d0;
    if (!sample.counting_down) begin
      if (d0 < 0) d_unwrap = d0 + $signed({2'b00, counter_period});
    end else begin
      if (d0 > 0) d_unwrap = d0 - $signed({2'b00, counter_period});
    end
  end

  assign delta_mag = delta[17] ? 17'(-delta) : 17'(delta);
  assign filt_mag  = filt[VEL_W-1] ? VEL_W'(-filt) : VEL_W'(filt);
  assign vel_mag   = vel[VEL_W-1] ? VEL_W'(-vel) : VEL_W'(vel);
  assign diff      = 33'(raw) - 33'(filt);
  assign filt_sum  = 36'(filt) + 36'(prod >>> 16);

  // reduction factor pieces
  assign cpr_eff  = (counts_per_rev == '0) ? 16'd1 : counts_per_rev;
  assign chan_eff = single_channel ? {1'b0, cpr_eff} : {cpr_eff, 1'b0};
  assign gear_eff = (!after_gear && gear_ratio >= GEAR_MIN) ? gear_ratio : GEAR_UNIT;

  // divider request
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    case (state)
      ST_MUL1: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NW'(delta_mag) * DIV_NW'(RAW_SCALE);
        div_req.den   = DIV_DW'(dt);
      end
      ST_VSTART: begin
        div_req.start = 1'b1;
        div_req.num   = {4'b0000, filt_mag, 16'h0000};
        div_req.den   = den;
      end
      ST_MUL3: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NW'(vel_mag) * DIV_NW'(dt);
        div_req.den   = US_PER_S;
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = (sample.dt_us == '0) ? ST_DONE : ST_MUL1;
      ST_MUL1:   state_next = ST_DIV1;
      ST_DIV1:   if (div_stat.done) state_next = ST_FILT1;
      ST_FILT1:  state_next = ST_FILT2;
      ST_FILT2:  state_next = ST_VSTART;
      ST_VSTART: state_next = ST_DIV2;
      ST_DIV2:   if (div_stat.done) state_next = ST_MUL3;
      ST_MUL3:   state_next = ST_DIV3;
      ST_DIV3:   if (div_stat.done) state_next = ST_DONE;
      ST_DONE:   if (!out_valid || result.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      counter_period <= 16'hFFFF;
      filter_alpha   <= ALPHA_ONE;
      counts_per_rev <= '0;
      single_channel <= 1'b0;
      after_gear     <= 1'b0;
      gear_ratio     <= '0;
      inverted       <= 1'b0;
      last_count     <= '0;
      filt           <= '0;
      pos_accum      <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_PERIOD:     counter_period <= cfg_data[15:0];
          CFG_ALPHA:      filter_alpha <= (cfg_data > ALPHA_ONE) ? ALPHA_ONE : cfg_data;
          CFG_CPR:        counts_per_rev <= cfg_data[15:0];
          CFG_SINGLE:     single_channel <= cfg_data[0];
          CFG_AFTER_GEAR: after_gear <= cfg_data[0];
          CFG_GEAR:       gear_ratio <= cfg_data[15:0];
          CFG_INVERT:     inverted <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) last_count <= sample.count;
      if (state == ST_FILT2) begin
        if (filt_sum > 36'sh07FFFFFFF)       filt <= 32'sh7FFFFFFF;
        else if (filt_sum < -36'sh080000000) filt <= 32'sh80000000;
        else                                 filt <= filt_sum[31:0];
      end
      if (state == ST_DIV3 && div_stat.done) begin
        if (vel[VEL_W-1]) pos_accum <= pos_accum - $signed(div_quo[POS_W-1:0]);
        else              pos_accum <= pos_accum + $signed(div_quo[POS_W-1:0]);
      end
      if (state == ST_DONE && (!out_valid || result.ready)) out_valid <= 1'b1;
      else if (out_take)                                     out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      delta   <= d_unwrap;
      dt      <= sample.dt_us;
      zero_dt <= (sample.dt_us == '0);
    end
    if (state == ST_DIV1 && div_stat.done) raw <= sat_mag(delta > 0, div_quo);
    if (state == ST_FILT1) begin
      prod <= diff * $signed({1'b0, filter_alpha});
      den  <= DIV_DW'(chan_eff) * DIV_DW'(gear_eff);
    end
    if (state == ST_DIV2 && div_stat.done) vel <= sat_mag(filt[VEL_W-1] ^ inverted, div_quo);
    if (state == ST_DONE && (!out_valid || result.ready)) begin
      out_vel  <= zero_dt ? '0 : vel;
      out_pos  <= pos_accum;
      out_vres <= !zero_dt;
    end
  end

  assign result.valid     = out_valid;
  assign result.velocity  = out_vel;
  assign result.position  = out_pos;
  assign result.valid_res = out_vres;

  // checks
  `EVEL_ASSERT_NOW(a_div_start_idle, clk, rst, div_req.start, !div_stat.busy, "divider restarted while busy")
  `EVEL_ASSERT_NOW(a_div_done_state, clk, rst, div_stat.done, (state == ST_DIV1 || state == ST_DIV2 || state == ST_DIV3), "divider finished outside a wait state")
  `EVEL_ASSERT_NEXT(a_zero_vel, clk, rst, state == ST_DONE && zero_dt && (!out_valid || result.ready), result.velocity == '0 && !result.valid_res, "zero dt word not flagged")

endmodule

// ----- verif/tb_encoder_velocity_estimator_core.sv -----
// Testbench for the encoder velocity estimator: random stream stimulus, predictor and scoreboard
`timescale 1ns / 1ps

module tb_encoder_velocity_estimator_core;
  import evel_pkg::*;

  // Scoreboard: speed/position predictor plus queue of expected result words
  class velocity_scoreboard;
    typedef struct {
      logic signed [VEL_W-1:0] velocity;
      logic signed [POS_W-1:0] position;
      logic                    valid_res;
    } motion_t;

    motion_t        pending_q[$];
    int             mismatches;
    // register copies
    longint         period, alpha, cpr, gear;
    bit             single, after_gear, invert;
    // block state copies
    longint         prev_count, filt_speed;
    logic [POS_W-1:0] pos_acc;

    function new();
      period = 65535; alpha = 65536; cpr = 0; gear = 0;
      single = 0; after_gear = 0; invert = 0;
      prev_count = 0; filt_speed = 0; pos_acc = '0;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_PERIOD:     period = val[15:0];
        CFG_ALPHA:      alpha = (val > 65536) ? 65536 : val;
        CFG_CPR:        cpr = val[15:0];
        CFG_SINGLE:     single = val[0];
        CFG_AFTER_GEAR: after_gear = val[0];
        CFG_GEAR:       gear = val[15:0];
        CFG_INVERT:     invert = val[0];
        default: ;
      endcase
    endfunction

    static function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void note_input(logic [COUNT_W-1:0] cnt, logic down, logic [DT_W-1:0] dt);
      longint delta, num, mag, raw, den, vel, step;
      bit neg;
      motion_t m;
      delta = longint'(cnt) - prev_count;
      prev_count = cnt;
      if (dt == 0) begin
        m.velocity = '0; m.position = pos_acc; m.valid_res = 1'b0;
        pending_q.push_back(m);
        return;
      end
      // unwrap in counting direction
      if (!down && delta < 0) delta += period;
      if (down && delta > 0) delta -= period;
      // raw speed Q24.8, negated
      num = -delta * 256000000;
      neg = num < 0;
      mag = (neg ? -num : num) / longint'(dt);
      if (mag > 64'h80000000) mag = 64'h80000000;
      raw = clamp32(neg ? -mag : mag);
      // IIR filter, floor of the weighted step
      filt_speed = clamp32(filt_speed + (((raw - filt_speed) * alpha) >>> 16));
      // reduction factor Q8.8
      den = (cpr != 0) ? cpr : 1;
      if (!single) den *= 2;
      den *= (!after_gear && gear >= 3) ? gear : 256;
      neg = filt_speed < 0;
      mag = ((neg ? -filt_speed : filt_speed) << 16) / den;
      if (invert) neg = !neg;
      if (mag > 64'h80000000) mag = 64'h80000000;
      vel = clamp32(neg ? -mag : mag);
      // position increment, truncating toward zero
      step = ((vel < 0 ? -vel : vel) * longint'(dt)) / 1000000;
      if (vel < 0) step = -step;
      pos_acc = pos_acc + step[POS_W-1:0];
      m.velocity = vel[VEL_W-1:0]; m.position = pos_acc; m.valid_res = 1'b1;
      pending_q.push_back(m);
    endfunction

    function void check_result(logic signed [VEL_W-1:0] vel, logic signed [POS_W-1:0] pos,
                               logic vr);
      motion_t m;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word vel=%0d pos=%0d", vel, pos);
        return;
      end
      m = pending_q.pop_front();
      if (vel !== m.velocity || pos !== m.position || vr !== m.valid_res) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp vel=%0d pos=%0d vr=%0b  got vel=%0d pos=%0d vr=%0b",
                   m.velocity, m.position, m.valid_res, vel, pos, vr);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  evel_in_if  sample_if();
  evel_out_if result_if();

  encoder_velocity_estimator_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sample(sample_if), .result(result_if)
  );

  velocity_scoreboard sb = new();
  bit quiet;
  int stall_left = 0;
  logic [COUNT_W-1:0] sent_count;
  int cur_period;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // mostly short gaps, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (rst || quiet) begin
      result_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
      stall_left <= gap_len();
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready)
      sb.check_result(result_if.velocity, result_if.position, result_if.valid_res);
  end

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
    if (idx == CFG_PERIOD) cur_period = val[15:0];
  endtask

  // send one word, then an optional idle gap
  task automatic send_word(logic [COUNT_W-1:0] cnt, logic down, logic [DT_W-1:0] dt);
    int g;
    sample_if.valid <= 1'b1;
    sample_if.count <= cnt;
    sample_if.counting_down <= down;
    sample_if.dt_us <= dt;
    do @(posedge clk); while (!sample_if.ready);
    sb.note_input(cnt, down, dt);
    sent_count = cnt;
    g = quiet ? 0 : gap_len();
    if (g > 0) begin
      sample_if.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    sample_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [DT_W-1:0] pick_dt();
    case ($urandom_range(0, 19))
      0:       return '0;
      1, 2:    return DT_W'($urandom_range(1, 10));
      3, 4:    return DT_W'($urandom());
      default: return DT_W'($urandom_range(50, 5000));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick16();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 17'h0FFFF;
      default: return CFG_DATA_W'($urandom_range(1, 65535));
    endcase
  endfunction

  initial begin
    int step, nxt;
    logic dn;
    rst = 1'b1; cfg_we <= 1'b0; cfg_index <= CFG_PERIOD; cfg_data <= '0;
    sample_if.valid <= 1'b0; sample_if.count <= '0;
    sample_if.counting_down <= 1'b0; sample_if.dt_us <= '0;
    quiet = 1'b1; cur_period = 65535; sent_count = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, zero time, saturation, wrap in both directions
    send_word(16'd0, 1'b0, 20'd0);
    send_word(16'd10, 1'b0, 20'd0);
    send_word(16'd20, 1'b0, 20'd1000);
    send_word(16'hFFFF, 1'b0, 20'd1);
    send_word(16'd5, 1'b0, 20'hFFFFF);
    send_word(16'd1, 1'b1, 20'd100);
    send_word(16'hFFF0, 1'b1, 20'd1);
    send_word(16'hFFF0, 1'b1, 20'd500);
    send_word(16'd3, 1'b0, 20'd250);
    drain();
    write_reg(CFG_ALPHA, 17'h1FFFF);     // above one acts as one
    write_reg(CFG_PERIOD, 17'd0);         // period zero: no unwrap
    write_reg(CFG_SINGLE, 17'd1);
    write_reg(CFG_AFTER_GEAR, 17'd1);
    write_reg(CFG_INVERT, 17'd1);
    send_word(16'd100, 1'b0, 20'd1);
    send_word(16'd0, 1'b0, 20'd1);
    send_word(16'd50, 1'b1, 20'd1);
    send_word(16'hFFFF, 1'b1, 20'd3);
    send_word(16'h8000, 1'b0, 20'd0);
    drain();
    write_reg(CFG_PERIOD, 17'd1000);      // readings above the period
    write_reg(CFG_ALPHA, 17'd0);
    write_reg(CFG_GEAR, 17'd3);
    write_reg(CFG_AFTER_GEAR, 17'd0);
    write_reg(CFG_CPR, 17'd65535);
    send_word(16'd5000, 1'b0, 20'd10);
    send_word(16'd10, 1'b0, 20'd10);
    send_word(16'd900, 1'b1, 20'd10);
    drain();

    // random phases, each with a new register setting
    for (int ph = 0; ph < 8; ph++) begin
      quiet = (ph == 3);
      case ($urandom_range(0, 3))
        0: write_reg(CFG_PERIOD, 17'd1);
        1: write_reg(CFG_PERIOD, 17'd65535);
        default: write_reg(CFG_PERIOD, CFG_DATA_W'($urandom_range(100, 65535)));
      endcase
      case ($urandom_range(0, 4))
        0: write_reg(CFG_ALPHA, 17'd0);
        1: write_reg(CFG_ALPHA, 17'd65536);
        2: write_reg(CFG_ALPHA, CFG_DATA_W'($urandom_range(65537, 131071)));
        default: write_reg(CFG_ALPHA, CFG_DATA_W'($urandom_range(1, 65535)));
      endcase
      write_reg(CFG_CPR, pick16());
      write_reg(CFG_SINGLE, CFG_DATA_W'($urandom_range(0, 1)));
      write_reg(CFG_AFTER_GEAR, CFG_DATA_W'($urandom_range(0, 1)));
      case ($urandom_range(0, 4))
        0: write_reg(CFG_GEAR, CFG_DATA_W'($urandom_range(0, 2)));
        1: write_reg(CFG_GEAR, 17'd3);
        default: write_reg(CFG_GEAR, pick16());
      endcase
      write_reg(CFG_INVERT, CFG_DATA_W'($urandom_range(0, 1)));
      for (int n = 0; n < 240; n++) begin
        if ($urandom_range(0, 99) < 15) begin
          send_word(COUNT_W'($urandom()), 1'($urandom_range(0, 1)), pick_dt());
        end else begin
          // plausible motion: small step in the counting direction, wrapped
          dn = 1'($urandom_range(0, 1));
          step = $urandom_range(0, 300);
          nxt = dn ? int'(sent_count) - step : int'(sent_count) + step;
          if (cur_period > 0) begin
            nxt = nxt % (cur_period + 1);
            if (nxt < 0) nxt += cur_period + 1;
          end
          send_word(nxt[COUNT_W-1:0], dn, pick_dt());
        end
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("tb_encoder_velocity_estimator_core: PASS");
    end else begin
      $display("tb_encoder_velocity_estimator_core: FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #50ms;
    $display("tb_encoder_velocity_estimator_core: FAIL");
    $finish;
  end

endmodule
